[hw/rtl/mwsl_pkg.sv]
// ----------------------------------------------------------------------------
// mwsl_pkg
// Types and constants shared by the mecanum wheel speed limiter pipeline.
// ----------------------------------------------------------------------------
package mwsl_pkg;

   localparam logic [1:0] REG_GEOMETRY_SUM = 2'd0;
   localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
   localparam logic [1:0] REG_SPEED_LIMIT  = 2'd2;

   localparam logic [15:0] GEOMETRY_SUM_RESET = 16'd0;
   localparam logic [23:0] SPEED_GAIN_RESET   = 24'd65536;
   localparam logic [14:0] SPEED_LIMIT_RESET  = 15'd32767;

   // motors one and three take the negated wheel speed
   localparam logic [3:0] NEG_LANES = 4'b0101;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = 15;

   typedef struct packed {
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] yaw_rate;
   } in_type;

   typedef struct packed {
      logic signed [15:0] motor_speed_one;
      logic signed [15:0] motor_speed_two;
      logic signed [15:0] motor_speed_three;
      logic signed [15:0] motor_speed_four;
      logic               limited;
   } out_type;

   typedef struct packed {
      logic [3:0]       neg;
      logic [3:0][14:0] mag;
   } scaled_type;

   typedef struct packed {
      logic [3:0]       neg;
      logic             limited;
      logic [14:0]      largest;
      logic [3:0][14:0] mag;
      logic [3:0][29:0] prod;
   } limit_type;

   typedef struct packed {
      logic [3:0]       neg;
      logic             limited;
      logic [14:0]      largest;
      logic [3:0][14:0] mag;
      logic [3:0][29:0] prod;
      logic [3:0][14:0] rem;
      logic [3:0][14:0] quot;
   } div_st_type;

   typedef struct packed {
      logic [3:0]       neg;
      logic             limited;
      logic [3:0][14:0] mag;
      logic [3:0][14:0] quot;
   } div_out_type;

endpackage

[hw/rtl/mwsl_scale.sv]
// ----------------------------------------------------------------------------
// mwsl_scale
// Five stage inverse kinematics: wheel speeds, magnitude, gain product,
// truncation and saturation to 15 bit motor speed magnitudes.
// ----------------------------------------------------------------------------
module mwsl_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         geometry_sum,
   input  logic [23:0]         speed_gain,
   input  logic                in_valid,
   output logic                in_stall,
   input  mwsl_pkg::in_type    in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output mwsl_pkg::scaled_type out_data
);

   logic [4:0] vld_ff;
   logic [4:0] adv;

   // stage 1
   logic signed [31:0] x_ff, y_ff;
   logic signed [40:0] rl_ff, rl_in;
   // stage 2
   logic signed [41:0] w_ff [4];
   logic signed [41:0] w_in [4];
   logic signed [41:0] xe, ye, rle;
   // stage 3
   logic [40:0] abs_ff [4];
   logic [40:0] abs_in [4];
   logic [3:0]  sgn_ff;
   // stage 4
   logic [48:0] phi_ff [4];
   logic [39:0] plo_ff [4];
   logic [48:0] phi_in [4];
   logic [39:0] plo_in [4];
   logic [3:0]  sgn4_ff;
   // stage 5
   mwsl_pkg::scaled_type res_ff, res_in;

   assign adv[4] = !vld_ff[4] || !out_stall;
   assign adv[3] = !vld_ff[3] || adv[4];
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];
   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
         if (adv[4]) vld_ff[4] <= vld_ff[3];
      end
   end

   assign rl_in = in_data.yaw_rate * $signed({1'b0, geometry_sum});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff  <= $signed({in_data.vel_x, 8'd0});
         y_ff  <= $signed({in_data.vel_y, 8'd0});
         rl_ff <= rl_in;
      end
   end

   always_comb begin
      xe  = 42'(x_ff);
      ye  = 42'(y_ff);
      rle = 42'(rl_ff);
      w_in[0] = -xe - ye + rle;
      w_in[1] = -xe + ye - rle;
      w_in[2] = -xe + ye + rle;
      w_in[3] = -xe - ye - rle;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         w_ff <= w_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         abs_in[i] = w_ff[i][41] ? 41'(-w_ff[i]) : w_ff[i][40:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         abs_ff <= abs_in;
         for (int i = 0; i < 4; i++) begin
            sgn_ff[i] <= w_ff[i][41] ^ mwsl_pkg::NEG_LANES[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         phi_in[i] = 49'(abs_ff[i][40:16]) * 49'(speed_gain);
         plo_in[i] = 40'(abs_ff[i][15:0]) * 40'(speed_gain);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         sgn4_ff <= sgn_ff;
      end
   end

   always_comb begin
      logic [49:0] sum;
      res_in.neg = sgn4_ff;
      for (int i = 0; i < 4; i++) begin
         sum = 50'(phi_ff[i]) + 50'(plo_ff[i][39:16]);
         res_in.mag[i] = (|sum[49:31]) ? 15'h7FFF : sum[30:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_data  = res_ff;

endmodule

[hw/rtl/mwsl_limit.sv]
// ----------------------------------------------------------------------------
// mwsl_limit
// Largest magnitude, limit compare and the limit products fed to the divider.
// ----------------------------------------------------------------------------
module mwsl_limit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [14:0]          speed_limit,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  mwsl_pkg::scaled_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output mwsl_pkg::limit_type  out_data
);

   logic [1:0] vld_ff;
   logic [1:0] adv;

   mwsl_pkg::scaled_type mx_ff;
   logic [14:0]          largest_ff, largest_in;
   logic                 lim_flag_ff;
   logic [14:0]          m01, m23;

   mwsl_pkg::limit_type res_ff, res_in;

   assign adv[1]   = !vld_ff[1] || !out_stall;
   assign adv[0]   = !vld_ff[0] || adv[1];
   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
      end
   end

   assign m01 = (in_data.mag[0] > in_data.mag[1]) ? in_data.mag[0] : in_data.mag[1];
   assign m23 = (in_data.mag[2] > in_data.mag[3]) ? in_data.mag[2] : in_data.mag[3];
   assign largest_in = (m01 > m23) ? m01 : m23;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mx_ff       <= in_data;
         largest_ff  <= largest_in;
         lim_flag_ff <= largest_in > speed_limit;
      end
   end

   always_comb begin
      res_in.neg     = mx_ff.neg;
      res_in.limited = lim_flag_ff;
      res_in.largest = largest_ff;
      res_in.mag     = mx_ff.mag;
      for (int i = 0; i < 4; i++) begin
         res_in.prod[i] = 30'(mx_ff.mag[i]) * 30'(speed_limit);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_data  = res_ff;

endmodule

[hw/rtl/mwsl_div.sv]
// ----------------------------------------------------------------------------
// mwsl_div
// Pipelined restoring divider, four lanes, one quotient bit per stage:
// quot = prod / largest, where prod < largest * 2^15.
// ----------------------------------------------------------------------------
module mwsl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  mwsl_pkg::limit_type   in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output mwsl_pkg::div_out_type out_data
);

   localparam int LAST = mwsl_pkg::DIV_STAGES - 1;

   logic [LAST:0]        vld_ff;
   logic [LAST:0]        adv;
   mwsl_pkg::div_st_type st_ff [mwsl_pkg::DIV_STAGES];
   mwsl_pkg::div_st_type head;

   always_comb begin
      head.neg     = in_data.neg;
      head.limited = in_data.limited;
      head.largest = in_data.largest;
      head.mag     = in_data.mag;
      head.prod    = in_data.prod;
      head.quot    = '0;
      for (int i = 0; i < 4; i++) begin
         head.rem[i] = in_data.prod[i][29:15];
      end
   end

   for (genvar k = 0; k < mwsl_pkg::DIV_STAGES; k++) begin : g_stage
      mwsl_pkg::div_st_type src;
      mwsl_pkg::div_st_type st_in;
      logic                 vld_src;

      if (k == 0) begin : g_head
         assign src     = head;
         assign vld_src = in_valid;
      end else begin : g_body
         assign src     = st_ff[k-1];
         assign vld_src = vld_ff[k-1];
      end

      if (k == LAST) begin : g_tail
         assign adv[k] = !vld_ff[k] || !out_stall;
      end else begin : g_mid
         assign adv[k] = !vld_ff[k] || adv[k+1];
      end

      always_comb begin
         logic [15:0] t;
         logic [15:0] d;
         st_in = src;
         d = {1'b0, src.largest};
         for (int i = 0; i < 4; i++) begin
            t = {src.rem[i], src.prod[i][LAST-k]};
            if (t >= d) begin
               st_in.rem[i]  = 15'(t - d);
               st_in.quot[i] = {src.quot[i][13:0], 1'b1};
            end else begin
               st_in.rem[i]  = t[14:0];
               st_in.quot[i] = {src.quot[i][13:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign in_stall = !adv[0];

   assign out_valid        = vld_ff[LAST];
   assign out_data.neg     = st_ff[LAST].neg;
   assign out_data.limited = st_ff[LAST].limited;
   assign out_data.mag     = st_ff[LAST].mag;
   assign out_data.quot    = st_ff[LAST].quot;

endmodule

[hw/rtl/mecanum_wheel_speed_limiter_core.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_limiter_core
// Chassis velocity to four mecanum wheel motor speeds with proportional
// limiting.
//
// req_ channel: one chassis command (vel_x, vel_y, yaw_rate) per item,
// taken when req_valid is high and req_stall low.
// rsp_ channel: one item of four motor speeds and the limited flag per
// command, in order, taken when rsp_valid is high and rsp_stall low.
// csr_ port: write geometry_sum, speed_gain or speed_limit with csr_we,
// only while no item is in flight; other indexes are ignored.
// Pipeline: 5 kinematics and gain stages, 2 limit stages,
// 15 divider stages (one quotient bit each) and the output register.
// Throughput is one item per cycle while rsp_stall stays low.
// Reset empties the pipeline and loads the register reset values.
// A stall on rsp_ holds the output item; stages behind it keep filling
// bubbles and req_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_limiter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mwsl_pkg::in_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mwsl_pkg::out_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   logic [15:0] geometry_sum_ff;
   logic [23:0] speed_gain_ff;
   logic [14:0] speed_limit_ff;

   logic                  sc_valid, sc_stall;
   mwsl_pkg::scaled_type  sc_data;
   logic                  lm_valid, lm_stall;
   mwsl_pkg::limit_type   lm_data;
   logic                  dv_valid, dv_stall;
   mwsl_pkg::div_out_type dv_data;

   logic              out_vld_ff;
   mwsl_pkg::out_type out_ff, out_in;
   logic              out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         geometry_sum_ff <= mwsl_pkg::GEOMETRY_SUM_RESET;
         speed_gain_ff   <= mwsl_pkg::SPEED_GAIN_RESET;
         speed_limit_ff  <= mwsl_pkg::SPEED_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mwsl_pkg::REG_GEOMETRY_SUM: geometry_sum_ff <= csr_wdata[15:0];
            mwsl_pkg::REG_SPEED_GAIN:   speed_gain_ff   <= csr_wdata;
            mwsl_pkg::REG_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   mwsl_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .geometry_sum (geometry_sum_ff),
      .speed_gain   (speed_gain_ff),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_data      (req_data),
      .out_valid    (sc_valid),
      .out_stall    (sc_stall),
      .out_data     (sc_data)
   );

   mwsl_limit u_limit (
      .clock       (clock),
      .reset       (reset),
      .speed_limit (speed_limit_ff),
      .in_valid    (sc_valid),
      .in_stall    (sc_stall),
      .in_data     (sc_data),
      .out_valid   (lm_valid),
      .out_stall   (lm_stall),
      .out_data    (lm_data)
   );

   mwsl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lm_valid),
      .in_stall  (lm_stall),
      .in_data   (lm_data),
      .out_valid (dv_valid),
      .out_stall (dv_stall),
      .out_data  (dv_data)
   );

   assign out_adv  = !out_vld_ff || !rsp_stall;
   assign dv_stall = !out_adv;

   always_comb begin
      logic [14:0]        v;
      logic signed [15:0] s [4];
      for (int i = 0; i < 4; i++) begin
         v    = dv_data.limited ? dv_data.quot[i] : dv_data.mag[i];
         s[i] = dv_data.neg[i] ? -$signed({1'b0, v}) : $signed({1'b0, v});
      end
      out_in.motor_speed_one   = s[0];
      out_in.motor_speed_two   = s[1];
      out_in.motor_speed_three = s[2];
      out_in.motor_speed_four  = s[3];
      out_in.limited           = dv_data.limited;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_adv) begin
         out_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

[tb/tb_mecanum_wheel_speed_limiter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mecanum_wheel_speed_limiter_core
// Checks the wheel speed pipeline against a cycle-free prediction of the
// inverse kinematics, gain, saturation and proportional limiting. A queue of
// chassis commands feeds a randomly idling driver; a randomly stalling monitor
// compares every motor speed item with the oldest predicted one. Register
// settings change between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_mecanum_wheel_speed_limiter_core;

   localparam logic [1:0] REG_UNUSED      = 2'd3;
   localparam int         PIPE_LATENCY    = 23;
   localparam int         WATCHDOG_CYCLES = 2000;
   localparam int         IDLE_PERCENT    = 21;
   localparam int         RANDOM_PHASES   = 14;
   localparam int         PHASE_ITEMS     = 114;
   localparam longint unsigned MOTOR_SAT  = 32767;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mwsl_pkg::in_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mwsl_pkg::out_type rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [23:0]       csr_wdata = '0;

   logic [15:0] geometry_sum_r = mwsl_pkg::GEOMETRY_SUM_RESET;
   logic [23:0] speed_gain_r   = mwsl_pkg::SPEED_GAIN_RESET;
   logic [14:0] speed_limit_r  = mwsl_pkg::SPEED_LIMIT_RESET;

   mwsl_pkg::in_type  pending_cmds[$];
   mwsl_pkg::out_type expected_speeds[$];
   logic    req_taken = 1'b0;
   logic    steady = 1'b0;
   int      errors = 0;
   int      cmds_sent = 0;
   int      speeds_checked = 0;
   int      limited_seen = 0;
   int      phases_run = 0;
   int      quiet_cycles = 0;

   mecanum_wheel_speed_limiter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic mwsl_pkg::out_type wheel_speeds(input mwsl_pkg::in_type cmd);
      longint vx, vy, vr;
      longint wheel [4];
      longint speed [4];
      longint unsigned mag, hi, lo, q, largest;
      mwsl_pkg::out_type res;
      vx = longint'($signed(cmd.vel_x)) * 256;
      vy = longint'($signed(cmd.vel_y)) * 256;
      vr = longint'($signed(cmd.yaw_rate)) * longint'(geometry_sum_r);
      wheel[0] = -vx - vy + vr;
      wheel[1] = -vx + vy - vr;
      wheel[2] = -vx + vy + vr;
      wheel[3] = -vx - vy - vr;
      largest = 0;
      for (int i = 0; i < 4; i++) begin
         mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
         hi = mag >> 16;
         lo = mag & 64'hFFFF;
         q = (hi * speed_gain_r + ((lo * speed_gain_r) >> 16)) >> 16;
         if (q > MOTOR_SAT) q = MOTOR_SAT;
         speed[i] = (wheel[i] < 0) ? -longint'(q) : longint'(q);
         if (mwsl_pkg::NEG_LANES[i]) speed[i] = -speed[i];
         mag = (speed[i] < 0) ? -speed[i] : speed[i];
         if (mag > largest) largest = mag;
      end
      res.limited = (largest > speed_limit_r);
      if (res.limited) begin
         for (int i = 0; i < 4; i++) begin
            mag = (speed[i] < 0) ? -speed[i] : speed[i];
            q = (mag * speed_limit_r) / largest;
            speed[i] = (speed[i] < 0) ? -longint'(q) : longint'(q);
         end
      end
      res.motor_speed_one   = speed[0][15:0];
      res.motor_speed_two   = speed[1][15:0];
      res.motor_speed_three = speed[2][15:0];
      res.motor_speed_four  = speed[3][15:0];
      return res;
   endfunction

   function automatic mwsl_pkg::in_type chassis_cmd(input int x, input int y, input int r);
      mwsl_pkg::in_type c;
      c.vel_x    = x[23:0];
      c.vel_y    = y[23:0];
      c.yaw_rate = r[23:0];
      return c;
   endfunction

   // mixed magnitudes so that small, mid and full scale velocities all occur
   function automatic int random_velocity();
      logic [23:0] raw;
      int width;
      raw = 24'($urandom());
      width = $urandom_range(1, 24);
      if (width < 24) raw = $signed(raw << (24 - width)) >>> (24 - width);
      case ($urandom_range(0, 19))
         0: raw = 24'h7FFFFF;
         1: raw = 24'h800000;
         2: raw = 24'h000000;
         3: raw = 24'hFFFFFF;
         default: ;
      endcase
      return int'($signed(raw));
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         mwsl_pkg::REG_GEOMETRY_SUM: geometry_sum_r = val[15:0];
         mwsl_pkg::REG_SPEED_GAIN:   speed_gain_r   = val;
         mwsl_pkg::REG_SPEED_LIMIT:  speed_limit_r  = val[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // upper bits beyond each register's width carry junk
   task automatic configure(input logic [15:0] geom, input logic [23:0] gain,
                            input logic [14:0] lim);
      write_reg(mwsl_pkg::REG_GEOMETRY_SUM, {8'($urandom()), geom});
      write_reg(mwsl_pkg::REG_SPEED_GAIN, gain);
      write_reg(mwsl_pkg::REG_SPEED_LIMIT, {9'($urandom()), lim});
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_speeds.size() != 0)
         @(posedge clock);
      phases_run++;
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_cmds.size() != 0 &&
             (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_data  <= pending_cmds.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_speeds.push_back(wheel_speeds(req_data));
         cmds_sent++;
      end
   end

   // monitor
   always @(posedge clock) begin
      mwsl_pkg::out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_speeds.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_speeds.pop_front();
            compare_field("motor_speed_one", $signed(want.motor_speed_one),
                          $signed(rsp_data.motor_speed_one));
            compare_field("motor_speed_two", $signed(want.motor_speed_two),
                          $signed(rsp_data.motor_speed_two));
            compare_field("motor_speed_three", $signed(want.motor_speed_three),
                          $signed(rsp_data.motor_speed_three));
            compare_field("motor_speed_four", $signed(want.motor_speed_four),
                          $signed(rsp_data.motor_speed_four));
            compare_field("limited", int'(want.limited), int'(rsp_data.limited));
            if (want.limited) limited_seen++;
            speeds_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: timeout, %0d items still outstanding", $time,
                  expected_speeds.size());
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] geom;
      logic [23:0] gain;
      logic [14:0] lim;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // register reset values: geometry zero, unit gain, full limit
      pending_cmds.push_back(chassis_cmd(0, 0, 0));
      pending_cmds.push_back(chassis_cmd(8388607, 0, 8388607));
      pending_cmds.push_back(chassis_cmd(-8388608, 0, 0));
      pending_cmds.push_back(chassis_cmd(0, 8388607, 0));
      pending_cmds.push_back(chassis_cmd(256, -256, -8388608));
      pending_cmds.push_back(chassis_cmd(-8388608, -8388608, -8388608));
      drain();

      // largest geometry, yaw alone and one mixed command
      configure(16'hFFFF, 24'd65536, 15'd32767);
      pending_cmds.push_back(chassis_cmd(0, 0, 8388607));
      pending_cmds.push_back(chassis_cmd(0, 0, -8388608));
      pending_cmds.push_back(chassis_cmd(0, 0, 256));
      pending_cmds.push_back(chassis_cmd(256, -512, -1));
      drain();

      // rescaling just at and just above the limit
      configure(16'd256, 24'd65536, 15'd1000);
      pending_cmds.push_back(chassis_cmd(256000, 0, 0));
      pending_cmds.push_back(chassis_cmd(256256, 0, 0));
      pending_cmds.push_back(chassis_cmd(512000, 256000, 25600));
      pending_cmds.push_back(chassis_cmd(-8388608, 8388607, 8388607));
      pending_cmds.push_back(chassis_cmd(0, 0, -300000));
      drain();

      // zero limit: nonzero speeds collapse, zero speeds pass unflagged
      configure(16'd256, 24'd65536, 15'd0);
      pending_cmds.push_back(chassis_cmd(0, 0, 0));
      pending_cmds.push_back(chassis_cmd(256, 0, 0));
      pending_cmds.push_back(chassis_cmd(1, 1, 1));
      drain();

      configure(16'd0, 24'd0, 15'd32767);
      pending_cmds.push_back(chassis_cmd(8388607, -8388608, 8388607));
      drain();
      configure(16'd0, 24'hFFFFFF, 15'd32767);
      pending_cmds.push_back(chassis_cmd(1, 0, 0));
      pending_cmds.push_back(chassis_cmd(2, 0, 0));
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               geom = 16'hFFFF; gain = 24'hFFFFFF; lim = 15'd32767;
            end
            1: begin
               geom = 16'd0; gain = 24'd0; lim = 15'd0;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: geom = 16'd0;
                  1: geom = 16'hFFFF;
                  default: geom = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
               endcase
               case ($urandom_range(0, 4))
                  0: gain = 24'd0;
                  1: gain = 24'hFFFFFF;
                  2: gain = 24'd65536;
                  default: gain = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
               endcase
               case ($urandom_range(0, 4))
                  0: lim = 15'd0;
                  1: lim = 15'd32767;
                  default: lim = 15'($urandom_range(0, 32767) >> $urandom_range(0, 14));
               endcase
            end
         endcase
         configure(geom, gain, lim);
         if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 24'($urandom()));
         steady = (phase == 4);
         repeat (PHASE_ITEMS)
            pending_cmds.push_back(chassis_cmd(random_velocity(), random_velocity(),
                                               random_velocity()));
         drain();
      end
      steady = 1'b0;

      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (expected_speeds.size() != 0) begin
         errors++;
         $display("%0t: %0d expected items never arrived", $time, expected_speeds.size());
      end
      $display("%0d chassis commands over %0d register settings, %0d motor speed items checked",
               cmds_sent, phases_run, speeds_checked);
      $display("%0d items rescaled to the limit, %0d mismatches", limited_seen, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
